// ----- hw/rtl/positional_list_engine_macros.svh -----
// ----------------------------------------------------------------------------
// Positional list engine: assertion macros
// Shared concurrent assertion forms used by the list engine RTL.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_IMPL(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("list engine same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("list engine next-cycle check failed");

`endif

// ----- hw/rtl/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// Positional list engine package
// Types, codes and default sizes shared by the list engine modules.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAP_DEF = 16;
  localparam int VAL_W = 32;
  localparam int POS_W = 6;
  localparam int ITEM_POS_W = 5;

  typedef enum logic [2:0] {
    OP_SHOW   = 3'd0,
    OP_APPEND = 3'd1,
    OP_POP    = 3'd2,
    OP_INSERT = 3'd3,
    OP_REMOVE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_GRAB,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH,
    S_SHOW_RD,
    S_SHOW_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]              op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } cmd_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] item_value;
    logic [ITEM_POS_W-1:0]   item_position;
    logic                    last;
  } rsp_t;

endpackage

// ----- hw/rtl/ple_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// Positional list engine
// Bounded ordered list of signed values with append, pop front, positional
// insert and remove, and an in-order show stream.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  cmd     | in        | cmd_valid, cmd_stall | cmd_t: op, value, position
//  rsp     | out       | rsp_valid, rsp_stall | rsp_t: status, item_value,
//          |           |                      |        item_position, last
//
// A command is taken only while the sequencer is idle; it is then decoded
// in the decode state, where errors and appends finish. Every entry moved
// by an insert or remove takes a read state and a write state, through the
// RAM's read and write ports; a remove first grabs the entry it takes, and
// both end in a finish state. Show reads and emits each entry in turn.
// Reset clears the element count and the sequencer; the entry store is not
// cleared, since only entries below the count are ever read.
// A stalled result holds the sequencer in its emitting state until transfer.
// ----------------------------------------------------------------------------
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAP = CAP_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

`include "positional_list_engine_macros.svh"

  localparam int AW = $clog2(CAP > 1 ? CAP : 2);
  localparam int CW = $clog2(CAP + 1);
  // Common compare width for counts, indices and positions, with headroom.
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  state_t state, state_next;

  // Command held for the whole of its processing.
  logic [2:0]              op;
  logic signed [VAL_W-1:0] val;
  logic [POS_W-1:0]        pos;

  logic [CW-1:0]    cnt;
  logic [CW-1:0]    idx;
  logic [VAL_W-1:0] hold;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  logic             emit;
  rsp_t             emit_data;
  logic             out_free;
  logic             load;

  logic [POS_W-1:0] eff_pos;
  logic [POS_W-1:0] pos_dn;
  logic [CW-1:0]    idx_dn;
  logic [XW-1:0]    xcnt;
  logic [XW-1:0]    xcnt_p1;
  logic [XW-1:0]    xidx;
  logic [XW-1:0]    xidx_p1;
  logic [XW-1:0]    xidx_m1;
  logic [XW-1:0]    xpos;
  logic             is_empty;
  logic             is_full;
  logic             ins_bad;
  logic             rem_bad;
  logic             is_insert;
  logic             shift_more;
  logic             show_last;
  logic             dec_err;
  status_t          dec_status;

  ple_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAP)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Pop front is handled as a remove at the first position.
  assign eff_pos   = (op == OP_POP) ? POS_W'(1) : pos;
  assign pos_dn    = eff_pos - POS_W'(1);
  assign idx_dn    = idx - CW'(1);
  assign xcnt      = XW'(cnt);
  assign xcnt_p1   = xcnt + XW'(1);
  assign xidx      = XW'(idx);
  assign xidx_p1   = xidx + XW'(1);
  assign xidx_m1   = xidx - XW'(1);
  assign xpos      = XW'(eff_pos);
  assign is_insert = (op == OP_INSERT);

  assign is_empty = (cnt == '0);
  assign is_full  = (xcnt >= XW'(CAP));
  assign ins_bad  = (xpos == '0) || (xpos > xcnt_p1);
  assign rem_bad  = (xpos == '0) || (xpos > xcnt);

  // Insert walks down from the tail, remove walks up from the hole.
  assign shift_more = is_insert ? (xidx_m1 >= xpos) : (xidx_p1 < xcnt);
  assign show_last  = (xidx_p1 == xcnt);

  assign out_free  = !rsp_valid || !rsp_stall;
  assign load      = emit && out_free;
  assign cmd_stall = (state != S_IDLE);

  // Error classification of the held command. The position check of an
  // insert comes before its full check.
  always_comb begin
    dec_err    = 1'b0;
    dec_status = ST_OK;
    case (op)
      OP_SHOW, OP_POP: begin
        dec_err    = is_empty;
        dec_status = ST_EMPTY;
      end
      OP_APPEND: begin
        dec_err    = is_full;
        dec_status = ST_FULL;
      end
      OP_INSERT: begin
        dec_err    = ins_bad || is_full;
        dec_status = ins_bad ? ST_BADPOS : ST_FULL;
      end
      OP_REMOVE: begin
        dec_err    = is_empty || rem_bad;
        dec_status = is_empty ? ST_EMPTY : ST_BADPOS;
      end
      default: begin
        dec_err    = 1'b0;
        dec_status = ST_OK;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op)
          OP_SHOW: begin
            if (dec_err) begin
              state_next = out_free ? S_IDLE : S_DECODE;
            end else begin
              state_next = S_SHOW_RD;
            end
          end
          OP_APPEND: begin
            state_next = out_free ? S_IDLE : S_DECODE;
          end
          OP_POP, OP_REMOVE: begin
            if (dec_err) begin
              state_next = out_free ? S_IDLE : S_DECODE;
            end else begin
              state_next = S_GRAB;
            end
          end
          OP_INSERT: begin
            if (dec_err) begin
              state_next = out_free ? S_IDLE : S_DECODE;
            end else begin
              state_next = (xcnt >= xpos) ? S_SHIFT_RD : S_FINISH;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_GRAB: begin
        state_next = (xpos < xcnt) ? S_SHIFT_RD : S_FINISH;
      end
      S_SHIFT_RD: begin
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        state_next = shift_more ? S_SHIFT_RD : S_FINISH;
      end
      S_FINISH: begin
        state_next = out_free ? S_IDLE : S_FINISH;
      end
      S_SHOW_RD: begin
        state_next = S_SHOW_EMIT;
      end
      S_SHOW_EMIT: begin
        if (out_free) begin
          state_next = show_last ? S_IDLE : S_SHOW_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: RAM port controls and the result to load.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    emit      = 1'b0;
    emit_data = '{status: ST_OK, item_value: '0, item_position: '0, last: 1'b1};
    case (state)
      S_DECODE: begin
        if (dec_err) begin
          emit             = (op == OP_SHOW) || (op == OP_APPEND) || (op == OP_POP) ||
                             (op == OP_INSERT) || (op == OP_REMOVE);
          emit_data.status = dec_status;
        end else if (op == OP_APPEND) begin
          emit                    = 1'b1;
          emit_data.item_value    = val;
          emit_data.item_position = xcnt_p1[ITEM_POS_W-1:0];
          ram_we                  = out_free;
          ram_waddr               = cnt[AW-1:0];
          ram_wdata               = val;
        end else if ((op == OP_POP) || (op == OP_REMOVE)) begin
          ram_re    = 1'b1;
          ram_raddr = pos_dn[AW-1:0];
        end
      end
      S_SHIFT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = is_insert ? idx_dn[AW-1:0] : idx[AW-1:0];
      end
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = is_insert ? idx[AW-1:0] : idx_dn[AW-1:0];
        ram_wdata = ram_rdata;
      end
      S_FINISH: begin
        emit                    = 1'b1;
        emit_data.item_value    = is_insert ? val : hold;
        emit_data.item_position = xpos[ITEM_POS_W-1:0];
        ram_we                  = is_insert && out_free;
        ram_waddr               = pos_dn[AW-1:0];
        ram_wdata               = val;
      end
      S_SHOW_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx[AW-1:0];
      end
      S_SHOW_EMIT: begin
        emit                    = 1'b1;
        emit_data.item_value    = ram_rdata;
        emit_data.item_position = xidx_p1[ITEM_POS_W-1:0];
        emit_data.last          = show_last;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      // The count moves only when the edit's result is transferred into
      // the output register.
      if (out_free && state == S_DECODE && op == OP_APPEND && !dec_err) begin
        cnt <= cnt + CW'(1);
      end else if (out_free && state == S_FINISH) begin
        cnt <= is_insert ? cnt + CW'(1) : cnt - CW'(1);
      end

      case (state)
        S_DECODE: begin
          idx <= is_insert ? cnt : ((op == OP_SHOW) ? '0 : CW'(eff_pos));
        end
        S_SHIFT_WR: begin
          idx <= is_insert ? idx - CW'(1) : idx + CW'(1);
        end
        S_SHOW_EMIT: begin
          if (out_free) begin
            idx <= idx + CW'(1);
          end
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      op  <= cmd.op;
      val <= cmd.value;
      pos <= cmd.position;
    end
    if (state == S_GRAB) begin
      hold <= ram_rdata;
    end
    if (load) begin
      rsp <= emit_data;
    end
  end

  `PLE_ASSERT_IMPL(a_cnt_bound, clk, rst, 1'b1, XW'(cnt) <= XW'(CAP))
  `PLE_ASSERT_NEXT(a_cnt_step, clk, rst, 1'b1, (cnt == $past(cnt)) || (cnt == $past(cnt) + CW'(1)) || (cnt == $past(cnt) - CW'(1)))
  `PLE_ASSERT_NEXT(a_last_idle, clk, rst, load && emit_data.last, state == S_IDLE)
  `PLE_ASSERT_IMPL(a_err_zero, clk, rst, rsp_valid && (rsp.status != ST_OK), (rsp.item_value == '0) && (rsp.item_position == '0) && rsp.last)

endmodule

// ----- bench/positional_list_engine_tb.sv -----
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Commands are sent to the list engine with random gaps on the command side
// and random stalls on the result side. A behavioural copy of the list runs
// beside the block and predicts every result. Each result transfer is
// checked field by field against the oldest prediction. A short table of
// directed commands comes first, then a fill to capacity, then random
// traffic that grows and drains the list many times over.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int CAP = CAP_DEF;

  // Op codes that the block must ignore: no result and no change of state.
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int RANDOM_EDITS = 170;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 1_000_000;

  // How a row of the directed table is checked.
  typedef enum {
    BY_MODEL,   // results come from the behavioural list
    TYPED,      // a single result written into the row
    SILENT      // the command must give no result at all
  } row_mode_t;

  typedef struct {
    logic [2:0]              op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    row_mode_t               mode;
    status_t                 status;
    logic signed [VAL_W-1:0] item_value;
    logic [ITEM_POS_W-1:0]   item_position;
  } plan_row_t;

  localparam int PLAN_LEN = 24;

  // Directed commands. The list starts empty after reset; the comment on each
  // row gives the list contents after it, front first.
  plan_row_t plan [PLAN_LEN] = '{
    '{OP_SHOW,     32'sd0,          6'd0,  TYPED,    ST_EMPTY,  32'sd0,          5'd0}, // ()
    '{OP_POP,      32'sd0,          6'd0,  TYPED,    ST_EMPTY,  32'sd0,          5'd0}, // ()
    '{OP_REMOVE,   32'sd0,          6'd1,  TYPED,    ST_EMPTY,  32'sd0,          5'd0}, // ()
    '{OP_REMOVE,   32'sd0,          6'd63, TYPED,    ST_EMPTY,  32'sd0,          5'd0}, // ()
    '{OP_INSERT,   32'sd5,          6'd0,  TYPED,    ST_BADPOS, 32'sd0,          5'd0}, // ()
    '{OP_INSERT,   32'sd5,          6'd2,  TYPED,    ST_BADPOS, 32'sd0,          5'd0}, // ()
    '{OP_SPARE_LO, -32'sd1,         6'd63, SILENT,   ST_OK,     32'sd0,          5'd0}, // ()
    '{OP_APPEND,   32'sh7FFF_FFFF,  6'd0,  TYPED,    ST_OK,     32'sh7FFF_FFFF,  5'd1}, // (max)
    '{OP_APPEND,   32'sh8000_0000,  6'd63, TYPED,    ST_OK,     32'sh8000_0000,  5'd2}, // (max min)
    '{OP_INSERT,   -32'sd1,         6'd1,  TYPED,    ST_OK,     -32'sd1,         5'd1}, // (-1 max min)
    '{OP_INSERT,   32'sd0,          6'd4,  TYPED,    ST_OK,     32'sd0,          5'd4}, // (-1 max min 0)
    '{OP_INSERT,   32'sd9,          6'd63, TYPED,    ST_BADPOS, 32'sd0,          5'd0},
    '{OP_INSERT,   32'sd9,          6'd6,  TYPED,    ST_BADPOS, 32'sd0,          5'd0},
    '{OP_SHOW,     32'sd0,          6'd0,  BY_MODEL, ST_OK,     32'sd0,          5'd0},
    '{OP_REMOVE,   32'sd0,          6'd0,  TYPED,    ST_BADPOS, 32'sd0,          5'd0},
    '{OP_REMOVE,   32'sd0,          6'd5,  TYPED,    ST_BADPOS, 32'sd0,          5'd0},
    '{OP_REMOVE,   32'sd0,          6'd4,  BY_MODEL, ST_OK,     32'sd0,          5'd0}, // (-1 max min)
    '{OP_REMOVE,   32'sd0,          6'd1,  BY_MODEL, ST_OK,     32'sd0,          5'd0}, // (max min)
    '{OP_POP,      32'sd0,          6'd0,  BY_MODEL, ST_OK,     32'sd0,          5'd0}, // (min)
    '{OP_SPARE_HI, 32'sh5555_5555,  6'd1,  SILENT,   ST_OK,     32'sd0,          5'd0},
    '{OP_INSERT,   32'sh5555_5555,  6'd2,  BY_MODEL, ST_OK,     32'sd0,          5'd0}, // (min 5..)
    '{OP_SHOW,     32'sd0,          6'd0,  BY_MODEL, ST_OK,     32'sd0,          5'd0},
    '{OP_POP,      32'sd0,          6'd0,  BY_MODEL, ST_OK,     32'sd0,          5'd0}, // (5..)
    '{OP_REMOVE,   32'sd0,          6'd1,  BY_MODEL, ST_OK,     32'sd0,          5'd0}  // ()
  };

  // Block ports. Every input has a known value from time zero.
  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Behavioural copy of the list, updated when a command transfer happens.
  logic signed [VAL_W-1:0] list_store [CAP];
  int   list_len = 0;

  rsp_t op_results [$];      // results of the command just applied
  rsp_t expected_rsp [$];    // results still owed by the block, oldest first

  int   errors      = 0;
  int   cycle_count = 0;
  bit   hold_req    = 1'b0;  // asks the result side for one long hold-off
  bit   growing     = 1'b1;  // random traffic tends to fill, or to drain
  int   quiet_left  = 0;     // commands still to be sent back to back

  positional_list_engine #(
    .CAP(CAP)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: the slowest correct run is far below this many cycles.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  function automatic rsp_t make_rsp(status_t s, logic signed [VAL_W-1:0] v, int p, bit l);
    rsp_t r;
    r.status        = s;
    r.item_value    = v;
    r.item_position = ITEM_POS_W'(p);
    r.last          = l;
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] op, logic signed [VAL_W-1:0] v, int p);
    cmd_t c;
    c.op       = op;
    c.value    = v;
    c.position = POS_W'(p);
    return c;
  endfunction

  // Applies one command to the behavioural list and leaves the results that
  // it gives in op_results. Any error leaves the list as it was.
  function automatic void apply_list_op(cmd_t c);
    int pos;
    logic signed [VAL_W-1:0] taken;
    pos = int'(c.position);
    op_results.delete();
    case (c.op)
      OP_SHOW: begin
        if (list_len == 0) begin
          op_results.push_back(make_rsp(ST_EMPTY, '0, 0, 1'b1));
        end else begin
          for (int i = 0; i < list_len; i++) begin
            op_results.push_back(make_rsp(ST_OK, list_store[i], i + 1, i + 1 == list_len));
          end
        end
      end
      OP_APPEND: begin
        if (list_len >= CAP) begin
          op_results.push_back(make_rsp(ST_FULL, '0, 0, 1'b1));
        end else begin
          list_store[list_len] = c.value;
          list_len++;
          op_results.push_back(make_rsp(ST_OK, c.value, list_len, 1'b1));
        end
      end
      OP_POP: begin
        if (list_len == 0) begin
          op_results.push_back(make_rsp(ST_EMPTY, '0, 0, 1'b1));
        end else begin
          taken = list_store[0];
          for (int i = 1; i < list_len; i++) list_store[i-1] = list_store[i];
          list_len--;
          op_results.push_back(make_rsp(ST_OK, taken, 1, 1'b1));
        end
      end
      OP_INSERT: begin
        // The position is judged before the list is found to be full.
        if (pos < 1 || pos > list_len + 1) begin
          op_results.push_back(make_rsp(ST_BADPOS, '0, 0, 1'b1));
        end else if (list_len >= CAP) begin
          op_results.push_back(make_rsp(ST_FULL, '0, 0, 1'b1));
        end else begin
          for (int i = list_len; i >= pos; i--) list_store[i] = list_store[i-1];
          list_store[pos-1] = c.value;
          list_len++;
          op_results.push_back(make_rsp(ST_OK, c.value, pos, 1'b1));
        end
      end
      OP_REMOVE: begin
        // An empty list wins over a bad position.
        if (list_len == 0) begin
          op_results.push_back(make_rsp(ST_EMPTY, '0, 0, 1'b1));
        end else if (pos < 1 || pos > list_len) begin
          op_results.push_back(make_rsp(ST_BADPOS, '0, 0, 1'b1));
        end else begin
          taken = list_store[pos-1];
          for (int i = pos; i < list_len; i++) list_store[i-1] = list_store[i];
          list_len--;
          op_results.push_back(make_rsp(ST_OK, taken, pos, 1'b1));
        end
      end
      default: ;
    endcase
  endfunction

  // Offers a command and returns at the clock edge where its transfer
  // happens. Valid and payload stay put for as long as the block stalls.
  task automatic offer(input cmd_t c);
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
  endtask

  task automatic issue(input cmd_t c);
    offer(c);
    apply_list_op(c);
    foreach (op_results[i]) expected_rsp.push_back(op_results[i]);
  endtask

  // Idle time between commands: mostly none, sometimes short, now
  // and then a long pause. Runs of back-to-back commands are mixed in.
  task automatic sender_gap();
    int gap;
    if (quiet_left > 0) begin
      quiet_left--;
      gap = 0;
    end else if ($urandom_range(0, 99) < 8) begin
      quiet_left = $urandom_range(15, 30);
      gap = 0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: gap = 0;
        11, 12, 13, 14, 15, 16:           gap = $urandom_range(1, 3);
        17, 18:                           gap = $urandom_range(4, 8);
        default:                          gap = $urandom_range(15, 40);
      endcase
    end
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender pause: lets every owed result arrive before the next command.
  task automatic wait_for_drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (expected_rsp.size() != 0);
  endtask

  // Random command. Most are well formed against the current list, with the
  // traffic swinging between filling and draining so that both the full and
  // the empty list come round again and again. The rest is noise: any op,
  // any position, and now and then an op code that the block ignores.
  task automatic next_random_cmd(output cmd_t c);
    int r;
    int w;
    r = $urandom_range(0, 99);
    c.value    = $urandom();
    c.position = POS_W'($urandom_range(0, 63));
    if (r < 3) begin
      c.op = 3'($urandom_range(int'(OP_SPARE_LO), int'(OP_SPARE_HI)));
    end else if (r < 13) begin
      c.op = 3'($urandom_range(int'(OP_SHOW), int'(OP_REMOVE)));
    end else begin
      if (list_len == CAP) growing = 1'b0;
      else if (list_len == 0) growing = 1'b1;
      w = $urandom_range(0, 99);
      if (w < 8) begin
        c.op = OP_SHOW;
      end else if (growing ? (w < 60) : (w < 25)) begin
        if ($urandom_range(0, 1) == 0) begin
          c.op = OP_APPEND;
        end else begin
          c.op       = OP_INSERT;
          c.position = POS_W'($urandom_range(1, list_len + 1));
        end
      end else begin
        if ($urandom_range(0, 9) < 4) begin
          c.op = OP_POP;
        end else begin
          c.op       = OP_REMOVE;
          c.position = POS_W'($urandom_range(1, (list_len > 0) ? list_len : 1));
        end
      end
    end
  endtask

  // Result side: random stall runs, free stretches, and on request one long
  // hold-off counted here, during which the block backs up onto its input.
  initial begin : result_side
    int  run_left;
    int  hold_left;
    bit  run_stall;
    run_left  = 0;
    hold_left = 0;
    run_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_stall = !run_stall;
          if (run_stall) begin
            run_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                  : $urandom_range(8, 30);
          end else begin
            run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 6);
          end
        end
        run_left--;
        rsp_stall <= run_stall;
      end
    end
  end

  // Result checker: each result transfer is matched with the oldest
  // prediction still owed.
  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        $error("result with nothing owed: status %0d, value %0d, position %0d, last %0d",
               rsp.status, rsp.item_value, rsp.item_position, rsp.last);
        errors++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          errors++;
        end
        if (rsp.item_value !== want.item_value) begin
          $error("item_value: expected %0d, got %0d", want.item_value, rsp.item_value);
          errors++;
        end
        if (rsp.item_position !== want.item_position) begin
          $error("item_position: expected %0d, got %0d", want.item_position,
                 rsp.item_position);
          errors++;
        end
        if (rsp.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, rsp.last);
          errors++;
        end
      end
    end
  end

  // Stimulus.
  initial begin : stimulus
    cmd_t c;
    int   edits_sent;
    bit   held;
    bit   paused;
    edits_sent = 0;
    held       = 1'b0;
    paused     = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table. The behavioural list is always updated; only rows
    // marked for it take their results from it.
    for (int k = 0; k < PLAN_LEN; k++) begin
      c = make_cmd(plan[k].op, plan[k].value, int'(plan[k].position));
      offer(c);
      apply_list_op(c);
      case (plan[k].mode)
        BY_MODEL: foreach (op_results[i]) expected_rsp.push_back(op_results[i]);
        TYPED:    expected_rsp.push_back(make_rsp(plan[k].status, plan[k].item_value,
                                                  int'(plan[k].item_position), 1'b1));
        SILENT:   ;
        default:  ;
      endcase
      sender_gap();
    end

    // Fill to capacity, then the cases that need a full list: append and
    // insert refused as full, a position past the end still reported as
    // bad, and a show that streams the largest number of results.
    while (list_len < CAP) begin
      issue(make_cmd(OP_APPEND, $urandom(), $urandom_range(0, 63)));
      sender_gap();
    end
    issue(make_cmd(OP_APPEND, $urandom(), 0));
    issue(make_cmd(OP_INSERT, $urandom(), CAP + 1));
    issue(make_cmd(OP_INSERT, $urandom(), CAP + 2));
    issue(make_cmd(OP_INSERT, $urandom(), 1));
    issue(make_cmd(OP_SHOW, 0, 0));
    issue(make_cmd(OP_REMOVE, 0, CAP));
    issue(make_cmd(OP_REMOVE, 0, 1));
    issue(make_cmd(OP_INSERT, $urandom(), CAP / 2));
    sender_gap();

    // Random traffic. Ignored op codes do not count as edits.
    while (edits_sent < RANDOM_EDITS) begin
      if (!held && edits_sent == 60) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && edits_sent == 150) begin
        paused = 1'b1;
        wait_for_drain();
      end
      next_random_cmd(c);
      issue(c);
      if (c.op <= OP_REMOVE) edits_sent++;
      sender_gap();
    end

    // Wait for the last results, then a while longer for anything stray.
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
